FILE: rtl/tsb_pkg.sv
// Texture sampler package: sizes, command codes and the request, result and
// pipeline structs shared by every stage. No dependencies.
package tsb_pkg;

  localparam int TEXELS    = 65536;
  localparam int ADDR_W    = $clog2(TEXELS);
  localparam int SLOTS     = 8;
  localparam int SLOT_W    = 3;
  localparam int CFG_IDX_W = 4;
  localparam int FRAC      = 16;
  localparam int DIM_W     = 13;
  localparam int DIV_STEPS = FRAC + 1;
  localparam int NUM_W     = 48;
  localparam int WT_W      = 33;
  localparam int PROD_W    = 49;
  localparam int ACC_W     = 48;
  localparam int NTAP      = 4;
  localparam int NCH       = 4;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_2D    = 3'd1;
  localparam logic [2:0] CMD_ARRAY = 3'd2;
  localparam logic [2:0] CMD_3D    = 3'd3;
  localparam logic [2:0] CMD_CUBE  = 3'd4;

  localparam logic [FRAC-1:0] HALF = FRAC'(1) << (FRAC - 1);

  typedef logic [63:0] texel_t;
  typedef logic [SLOTS-1:0][63:0] desc_arr_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        texel_addr;
    logic signed [15:0] wr_chan0;
    logic signed [15:0] wr_chan1;
    logic signed [15:0] wr_chan2;
    logic signed [15:0] wr_chan3;
  } in_t;

  typedef struct packed {
    logic signed [15:0] rd_chan0;
    logic signed [15:0] rd_chan1;
    logic signed [15:0] rd_chan2;
    logic signed [15:0] rd_chan3;
  } out_t;

  typedef struct packed {
    logic              wr;
    logic              emit;
    logic              absent;
    logic              cube;
    logic              ma_zero;
    logic [ADDR_W-1:0] wr_addr;
    texel_t            wr_data;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [ADDR_W-1:0] base;
    logic [DIM_W-1:0]  slice_a;
    logic [DIM_W-1:0]  slice_b;
    logic [FRAC-1:0]   tz;
    logic [FRAC-1:0]   u16;
    logic [FRAC-1:0]   v16;
  } front_t;

  typedef struct packed {
    logic                         wr;
    logic                         emit;
    logic                         absent;
    logic [ADDR_W-1:0]            wr_addr;
    texel_t                       wr_data;
    logic [NTAP-1:0][ADDR_W-1:0]  addr_a;
    logic [NTAP-1:0][ADDR_W-1:0]  addr_b;
    logic [NTAP-1:0][WT_W-1:0]    wt;
    logic [FRAC-1:0]              tz;
  } tap_t;

  function automatic logic [DIM_W-1:0] dim_f(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

endpackage

FILE: rtl/tsb_front.sv
// Request decode: descriptor lookup, slice and layer selection, cube face and
// division operands. Depends on tsb_pkg.
module tsb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  tsb_pkg::in_t       in_d,
  input  tsb_pkg::desc_arr_t desc,
  output logic               out_v,
  output tsb_pkg::front_t    out_f,
  output logic [47:0]        num_u,
  output logic [47:0]        num_v,
  output logic [31:0]        den
);
  import tsb_pkg::*;

  logic [SLOT_W-1:0]  sl;
  logic [63:0]        d;
  logic [DIM_W-1:0]   w, h, dep, dm1;
  logic [28:0]        fw;
  logic [DIM_W-1:0]   z0, z1;
  logic signed [32:0] lay;
  logic [DIM_W-1:0]   lay_c, face_c, slice_a;
  logic [31:0]        ax, ay, az, ma_c;
  logic signed [33:0] sx, sy, sz, s, t;
  logic [2:0]         face;
  logic [33:0]        su, tv;
  logic               xpos, ypos, zpos;
  front_t             f;

  always_comb begin
    sl  = (in_d.slot > 4'd7) ? SLOT_W'(0) : in_d.slot[SLOT_W-1:0];
    d   = desc[sl];
    w   = dim_f(d[13:1]);
    h   = dim_f(d[26:14]);
    dep = dim_f(d[39:27]);
    dm1 = dep - DIM_W'(1);

    fw = 29'(in_d.coord_z[15:0]) * 29'(dm1);
    z0 = fw[28:16];
    z1 = ({1'b0, z0} + 14'd1 < {1'b0, dep}) ? z0 + DIM_W'(1) : dm1;

    lay = {in_d.coord_z[31], in_d.coord_z} + 33'sd32768;
    if (lay[32]) begin
      lay_c = '0;
    end else if (lay[32:16] > {4'b0, dm1}) begin
      lay_c = dm1;
    end else begin
      lay_c = lay[28:16];
    end

    ax = in_d.coord_x[31] ? 32'(-in_d.coord_x) : in_d.coord_x;
    ay = in_d.coord_y[31] ? 32'(-in_d.coord_y) : in_d.coord_y;
    az = in_d.coord_z[31] ? 32'(-in_d.coord_z) : in_d.coord_z;
    sx = {{2{in_d.coord_x[31]}}, in_d.coord_x};
    sy = {{2{in_d.coord_y[31]}}, in_d.coord_y};
    sz = {{2{in_d.coord_z[31]}}, in_d.coord_z};
    xpos = !in_d.coord_x[31] && (in_d.coord_x != 0);
    ypos = !in_d.coord_y[31] && (in_d.coord_y != 0);
    zpos = !in_d.coord_z[31] && (in_d.coord_z != 0);

    priority if (ax >= ay && ax >= az) begin
      ma_c = ax;
      t    = -sy;
      if (xpos) begin
        face = 3'd0;
        s    = -sz;
      end else begin
        face = 3'd1;
        s    = sz;
      end
    end else if (ay >= az) begin
      ma_c = ay;
      s    = sx;
      if (ypos) begin
        face = 3'd2;
        t    = sz;
      end else begin
        face = 3'd3;
        t    = -sz;
      end
    end else begin
      ma_c = az;
      t    = -sy;
      if (zpos) begin
        face = 3'd4;
        s    = sx;
      end else begin
        face = 3'd5;
        s    = -sx;
      end
    end
    su = 34'(s + $signed({2'b0, ma_c}));
    tv = 34'(t + $signed({2'b0, ma_c}));
    face_c = ({10'b0, face} > dm1) ? dm1 : {10'b0, face};

    unique case (in_d.command)
      CMD_ARRAY: slice_a = lay_c;
      CMD_3D:    slice_a = z0;
      CMD_CUBE:  slice_a = face_c;
      default:   slice_a = '0;
    endcase

    f.wr      = (in_d.command == CMD_WRITE);
    f.emit    = (in_d.command == CMD_2D) || (in_d.command == CMD_ARRAY) ||
                (in_d.command == CMD_3D) || (in_d.command == CMD_CUBE);
    f.absent  = !d[0];
    f.cube    = (in_d.command == CMD_CUBE);
    f.ma_zero = (ma_c == '0);
    f.wr_addr = in_d.texel_addr[ADDR_W-1:0];
    f.wr_data = {in_d.wr_chan3, in_d.wr_chan2, in_d.wr_chan1, in_d.wr_chan0};
    f.w       = w;
    f.h       = h;
    f.base    = d[40 +: ADDR_W];
    f.slice_a = slice_a;
    f.slice_b = (in_d.command == CMD_3D) ? z1 : slice_a;
    f.tz      = (in_d.command == CMD_3D) ? fw[FRAC-1:0] : '0;
    f.u16     = in_d.coord_x[FRAC-1:0];
    f.v16     = in_d.coord_y[FRAC-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_f <= f;
      num_u <= {su[32:0], 15'b0};
      num_v <= {tv[32:0], 15'b0};
      den   <= ma_c;
    end
  end

endmodule

FILE: rtl/tsb_div.sv
// Pipelined restoring divider for the two cube face coordinates, one quotient
// bit per stage, with the request carried alongside. Depends on tsb_pkg.
module tsb_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  tsb_pkg::front_t in_f,
  input  logic [47:0]     num_u,
  input  logic [47:0]     num_v,
  input  logic [31:0]     den,
  output logic            out_v,
  output tsb_pkg::front_t out_f,
  output logic [16:0]     q_u,
  output logic [16:0]     q_v
);
  import tsb_pkg::*;

  localparam int REM_W = NUM_W + 1;
  localparam int LAST  = DIV_STEPS - 1;

  logic                 v_r  [DIV_STEPS];
  front_t               f_r  [DIV_STEPS];
  logic [NUM_W-1:0]     ru_r [DIV_STEPS];
  logic [NUM_W-1:0]     rv_r [DIV_STEPS];
  logic [31:0]          d_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] qu_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] qv_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 v_i;
    front_t               f_i;
    logic [NUM_W-1:0]     ru_i, rv_i;
    logic [31:0]          d_i;
    logic [DIV_STEPS-1:0] qu_i, qv_i;
    logic [REM_W-1:0]     dsh, tu, tv;

    if (k == 0) begin : g_head
      assign v_i  = in_v;
      assign f_i  = in_f;
      assign ru_i = num_u;
      assign rv_i = num_v;
      assign d_i  = den;
      assign qu_i = '0;
      assign qv_i = '0;
    end else begin : g_tail
      assign v_i  = v_r[k-1];
      assign f_i  = f_r[k-1];
      assign ru_i = ru_r[k-1];
      assign rv_i = rv_r[k-1];
      assign d_i  = d_r[k-1];
      assign qu_i = qu_r[k-1];
      assign qv_i = qv_r[k-1];
    end

    assign dsh = REM_W'(d_i) << (DIV_STEPS - 1 - k);
    assign tu  = {1'b0, ru_i} - dsh;
    assign tv  = {1'b0, rv_i} - dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[k]  <= f_i;
        d_r[k]  <= d_i;
        ru_r[k] <= tu[NUM_W] ? ru_i : tu[NUM_W-1:0];
        rv_r[k] <= tv[NUM_W] ? rv_i : tv[NUM_W-1:0];
        qu_r[k] <= {qu_i[DIV_STEPS-2:0], ~tu[NUM_W]};
        qv_r[k] <= {qv_i[DIV_STEPS-2:0], ~tv[NUM_W]};
      end
    end
  end

  assign out_v = v_r[LAST];
  assign out_f = f_r[LAST];
  assign q_u   = qu_r[LAST];
  assign q_v   = qv_r[LAST];

  a_rem_u: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && d_r[LAST] != '0 |-> ru_r[LAST] < NUM_W'(d_r[LAST]))
    else $error("u remainder not below divisor");
  a_rem_v: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && d_r[LAST] != '0 |-> rv_r[LAST] < NUM_W'(d_r[LAST]))
    else $error("v remainder not below divisor");

endmodule

FILE: rtl/tsb_addr.sv
// Texel coordinate pipeline: pixel position, neighbours, bilinear weights and
// texel addresses for both slices. Depends on tsb_pkg.
module tsb_addr (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  tsb_pkg::front_t in_f,
  input  logic [16:0]     q_u,
  input  logic [16:0]     q_v,
  output logic            out_v,
  output tsb_pkg::tap_t   out_t
);
  import tsb_pkg::*;

  logic [3:0] v_r;

  // stage C
  front_t            c_f;
  logic [28:0]       fx_r, fy_r;
  logic [FRAC-1:0]   uc, vc;
  // stage D
  front_t            d_f;
  logic [DIM_W-1:0]  x0_r, x1_r, y0_r, y1_r;
  logic [FRAC-1:0]   tx_r, ty_r;
  logic [ADDR_W-1:0] sha_r, shb_r;
  logic [DIM_W-1:0]  x0, y0;
  logic [25:0]       sha, shb;
  // stage E
  front_t                      e_f;
  logic [DIM_W-1:0]            ex0_r, ex1_r;
  logic [NTAP-1:0][ADDR_W-1:0] ra_r, rb_r;
  logic [NTAP-1:0][WT_W-1:0]   wt_r;
  logic [16:0]                 omx, omy;
  logic [NTAP-1:0][DIM_W-1:0]  ys;
  // stage F
  front_t                      f_f;
  logic [DIM_W-1:0]            fx0_r, fx1_r;
  logic [NTAP-1:0][ADDR_W-1:0] pa_r, pb_r;
  logic [NTAP-1:0][WT_W-1:0]   fwt_r;
  logic [NTAP-1:0][31:0]       pa, pb;
  // stage G
  tap_t                        g;
  logic [NTAP-1:0][DIM_W-1:0]  xs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[2:0], in_v};
      out_v <= v_r[3];
    end
  end

  always_comb begin
    uc = in_f.cube ? (in_f.ma_zero ? HALF : q_u[FRAC-1:0]) : in_f.u16;
    vc = in_f.cube ? (in_f.ma_zero ? HALF : q_v[FRAC-1:0]) : in_f.v16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_f  <= in_f;
      fx_r <= 29'(uc) * 29'(in_f.w - DIM_W'(1));
      fy_r <= 29'(vc) * 29'(in_f.h - DIM_W'(1));
    end
  end

  always_comb begin
    x0  = fx_r[28:16];
    y0  = fy_r[28:16];
    sha = 26'(c_f.slice_a) * 26'(c_f.h);
    shb = 26'(c_f.slice_b) * 26'(c_f.h);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_f   <= c_f;
      x0_r  <= x0;
      y0_r  <= y0;
      x1_r  <= ({1'b0, x0} + 14'd1 < {1'b0, c_f.w}) ? x0 + DIM_W'(1) : c_f.w - DIM_W'(1);
      y1_r  <= ({1'b0, y0} + 14'd1 < {1'b0, c_f.h}) ? y0 + DIM_W'(1) : c_f.h - DIM_W'(1);
      tx_r  <= fx_r[FRAC-1:0];
      ty_r  <= fy_r[FRAC-1:0];
      sha_r <= sha[ADDR_W-1:0];
      shb_r <= shb[ADDR_W-1:0];
    end
  end

  always_comb begin
    omx = 17'h10000 - {1'b0, tx_r};
    omy = 17'h10000 - {1'b0, ty_r};
    ys  = {y1_r, y1_r, y0_r, y0_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_f   <= d_f;
      ex0_r <= x0_r;
      ex1_r <= x1_r;
      for (int k = 0; k < NTAP; k++) begin
        ra_r[k] <= sha_r + ADDR_W'(ys[k]);
        rb_r[k] <= shb_r + ADDR_W'(ys[k]);
      end
      wt_r[0] <= WT_W'(omx) * WT_W'(omy);
      wt_r[1] <= WT_W'(tx_r) * WT_W'(omy);
      wt_r[2] <= WT_W'(omx) * WT_W'(ty_r);
      wt_r[3] <= WT_W'(tx_r) * WT_W'(ty_r);
    end
  end

  always_comb begin
    for (int k = 0; k < NTAP; k++) begin
      pa[k] = 32'(ra_r[k]) * 32'(e_f.w);
      pb[k] = 32'(rb_r[k]) * 32'(e_f.w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_f   <= e_f;
      fx0_r <= ex0_r;
      fx1_r <= ex1_r;
      fwt_r <= wt_r;
      for (int k = 0; k < NTAP; k++) begin
        pa_r[k] <= pa[k][ADDR_W-1:0];
        pb_r[k] <= pb[k][ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    xs        = {fx1_r, fx0_r, fx1_r, fx0_r};
    g.wr      = f_f.wr;
    g.emit    = f_f.emit;
    g.absent  = f_f.absent;
    g.wr_addr = f_f.wr_addr;
    g.wr_data = f_f.wr_data;
    g.wt      = fwt_r;
    g.tz      = f_f.tz;
    for (int k = 0; k < NTAP; k++) begin
      g.addr_a[k] = f_f.base + pa_r[k] + ADDR_W'(xs[k]);
      g.addr_b[k] = f_f.base + pb_r[k] + ADDR_W'(xs[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_t <= g;
    end
  end

endmodule

FILE: rtl/tsb_mem.sv
// One copy of the texel store: one write port, two registered read ports.
// Depends on tsb_pkg.
module tsb_mem (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [tsb_pkg::ADDR_W-1:0] waddr,
  input  tsb_pkg::texel_t            wdata,
  input  logic [tsb_pkg::ADDR_W-1:0] raddr_a,
  input  logic [tsb_pkg::ADDR_W-1:0] raddr_b,
  output tsb_pkg::texel_t            rdata_a,
  output tsb_pkg::texel_t            rdata_b
);
  import tsb_pkg::*;

  texel_t mem [TEXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/tsb_filter.sv
// Filter pipeline: per-texel weighting, tap sums, slice blend and rounding,
// ending in the result register. Depends on tsb_pkg.
module tsb_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  tsb_pkg::tap_t                 in_t,
  input  logic [tsb_pkg::NTAP-1:0][63:0] ta,
  input  logic [tsb_pkg::NTAP-1:0][63:0] tb,
  output logic                          out_v,
  output tsb_pkg::out_t                 out_d
);
  import tsb_pkg::*;

  logic [3:0] v_r;
  tap_t       h_r, i_r, j_r, k_r;

  logic [NTAP-1:0][NCH-1:0][PROD_W-1:0] pa_r, pb_r;
  logic [NCH-1:0][ACC_W-1:0]            aa_r, ab_r;
  logic [NCH-1:0][ACC_W:0]              sa, sb;
  logic [16:0]                          omz;
  logic [NCH-1:0][40:0]                 ahi_r, alo_r, bhi_r, blo_r;
  logic [NCH-1:0][65:0]                 vsum;
  logic [NCH-1:0][15:0]                 res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      out_v <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[2:0], in_v};
      out_v <= v_r[3] && k_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= in_t;
      i_r <= h_r;
      j_r <= i_r;
      k_r <= j_r;
      for (int k = 0; k < NTAP; k++) begin
        for (int c = 0; c < NCH; c++) begin
          pa_r[k][c] <= PROD_W'(ta[k][16*c +: 16] ^ 16'h8000) * PROD_W'(h_r.wt[k]);
          pb_r[k][c] <= PROD_W'(tb[k][16*c +: 16] ^ 16'h8000) * PROD_W'(h_r.wt[k]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sa[c] = (ACC_W+1)'(pa_r[0][c]) + (ACC_W+1)'(pa_r[1][c]) +
              (ACC_W+1)'(pa_r[2][c]) + (ACC_W+1)'(pa_r[3][c]);
      sb[c] = (ACC_W+1)'(pb_r[0][c]) + (ACC_W+1)'(pb_r[1][c]) +
              (ACC_W+1)'(pb_r[2][c]) + (ACC_W+1)'(pb_r[3][c]);
    end
    omz = 17'h10000 - {1'b0, j_r.tz};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        aa_r[c] <= sa[c][ACC_W-1:0];
        ab_r[c] <= sb[c][ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NCH; c++) begin
        ahi_r[c] <= 41'(aa_r[c][47:24]) * 41'(omz);
        alo_r[c] <= 41'(aa_r[c][23:0]) * 41'(omz);
        bhi_r[c] <= 41'(ab_r[c][47:24]) * 41'(j_r.tz);
        blo_r[c] <= 41'(ab_r[c][23:0]) * 41'(j_r.tz);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      vsum[c] = ((66'(ahi_r[c]) + 66'(bhi_r[c])) << 24) + 66'(alo_r[c]) +
                66'(blo_r[c]) + (66'd1 << 47);
      res[c]  = k_r.absent ? 16'h0000 : (vsum[c][63:48] ^ 16'h8000);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.rd_chan0 <= res[0];
      out_d.rd_chan1 <= res[1];
      out_d.rd_chan2 <= res[2];
      out_d.rd_chan3 <= res[3];
    end
  end

endmodule

FILE: rtl/texture_sampler_bilinear_cube_3d.sv
// Texture sampler top level: descriptors, decode, cube divider, address
// pipeline, four texel store copies and the filter. Depends on tsb_pkg.
// Throughput: one request per cycle while out_ready does not stall the
// output; four store copies with two read ports each serve all eight
// texels of a 3D sample together.
// Reset clears descriptors and pipeline valid bits; texel contents are kept.
module texture_sampler_bilinear_cube_3d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsb_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tsb_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import tsb_pkg::*;

  logic                  en;
  desc_arr_t             desc_r;
  logic                  fr_v, dv_v, tap_v;
  front_t                fr_f, dv_f;
  logic [NUM_W-1:0]      num_u, num_v;
  logic [31:0]           den;
  logic [DIV_STEPS-1:0]  q_u, q_v;
  tap_t                  tap;
  logic [NTAP-1:0][63:0] ta, tb;
  logic                  we;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign we        = en && tap_v && tap.wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(SLOTS)) begin
      desc_r[cfg_index[SLOT_W-1:0]] <= cfg_data;
    end
  end

  tsb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .in_d  (in_data),
    .desc  (desc_r),
    .out_v (fr_v),
    .out_f (fr_f),
    .num_u (num_u),
    .num_v (num_v),
    .den   (den)
  );

  tsb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (fr_v),
    .in_f  (fr_f),
    .num_u (num_u),
    .num_v (num_v),
    .den   (den),
    .out_v (dv_v),
    .out_f (dv_f),
    .q_u   (q_u),
    .q_v   (q_v)
  );

  tsb_addr u_addr (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (dv_v),
    .in_f  (dv_f),
    .q_u   (q_u),
    .q_v   (q_v),
    .out_v (tap_v),
    .out_t (tap)
  );

  for (genvar k = 0; k < NTAP; k++) begin : g_store
    tsb_mem u_mem (
      .clk     (clk),
      .en      (en),
      .we      (we),
      .waddr   (tap.wr_addr),
      .wdata   (tap.wr_data),
      .raddr_a (tap.addr_a[k]),
      .raddr_b (tap.addr_b[k]),
      .rdata_a (ta[k]),
      .rdata_b (tb[k])
    );
  end

  tsb_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (tap_v && !tap.wr),
    .in_t  (tap),
    .ta    (ta),
    .tb    (tb),
    .out_v (out_valid),
    .out_d (out_data)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({fr_v, dv_v, tap_v}))
    else $error("pipeline moved during a stall");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !fr_v && !tap_v)
    else $error("pipeline not empty after reset");

endmodule
